>>> src/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg: shared types and constants of the STK500v2 frame receiver
// Holds the configuration register map, message framing constants and the
// status codes of the final word of a message.
// ----------------------------------------------------------------------------
package stk_pkg;

    localparam int unsigned POS_W        = 17;
    localparam int unsigned OFFSET_W     = 10;
    localparam int unsigned HEADER_BYTES = 5;

    localparam logic [POS_W-1:0] POS_START  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SEQ    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(3);
    localparam logic [POS_W-1:0] POS_TOKEN  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_BODY   = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_MAX    = POS_W'(HEADER_BYTES + 65535);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CKSUM    = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_START_VALUE = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_TOKEN_VALUE = 3'd4;

    localparam logic [7:0] START_VALUE_RESET = 8'd27;
    localparam logic [7:0] TOKEN_VALUE_RESET = 8'd14;

    typedef struct packed {
        logic [7:0] start_value;
        logic [7:0] token_value;
    } cfg_t;

endpackage

>>> src/stk_if.sv
// ----------------------------------------------------------------------------
// stk_rx_if / stk_res_if: valid-ready channels of the frame receiver
// The receive channel carries one serial byte per word; the result channel
// carries one body byte or the final status of a message per word.
// ----------------------------------------------------------------------------
interface stk_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface stk_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [9:0]  offset;
    logic        last;
    logic [1:0]  status;
    logic [7:0]  sequence_res;
    logic [15:0] body_length;

    modport source (output valid, output data_byte, output offset, output last,
                    output status, output sequence_res, output body_length,
                    input ready);
    modport sink (input valid, input data_byte, input offset, input last,
                  input status, input sequence_res, input body_length,
                  output ready);
endinterface

>>> src/stk_cfg_regs.sv
// ----------------------------------------------------------------------------
// stk_cfg_regs: APB configuration registers
// Holds the expected start byte and token byte, written and read over APB.
// ----------------------------------------------------------------------------
module stk_cfg_regs
    import stk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_value <= START_VALUE_RESET;
            cfg_reg.token_value <= TOKEN_VALUE_RESET;
        end
        else if (wr_en)
        begin
            case (paddr)
                ADDR_START_VALUE: cfg_reg.start_value <= pwdata[7:0];
                ADDR_TOKEN_VALUE: cfg_reg.token_value <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_START_VALUE: prdata = {24'd0, cfg_reg.start_value};
            ADDR_TOKEN_VALUE: prdata = {24'd0, cfg_reg.token_value};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

>>> src/stk_frame_core.sv
// ----------------------------------------------------------------------------
// stk_frame_core: message parser with input and result registers
// Tracks the position within a message, the running XOR checksum, the
// sequence number and the body length, and produces one result word per
// body byte, unless the body exceeds MAX_BODY, and one final word per message.
// ----------------------------------------------------------------------------
module stk_frame_core
    import stk_pkg::*;
#(
    parameter int unsigned MAX_BODY = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    stk_rx_if.sink       rx,
    stk_res_if.source    res
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             advance;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       xor_reg;
    logic [7:0]       xor_next;
    logic [15:0]      length_reg;
    logic [15:0]      length_next;
    logic [7:0]       seq_reg;
    logic [7:0]       seq_next;

    logic             out_valid_reg;
    logic [7:0]       out_data_reg;
    logic [9:0]       out_offset_reg;
    logic             out_last_reg;
    logic [1:0]       out_status_reg;
    logic [7:0]       out_seq_reg;
    logic [15:0]      out_length_reg;

    logic             emit;
    logic [7:0]       data_next;
    logic [9:0]       offset_next;
    logic             last_next;
    logic [1:0]       status_next;

    logic [POS_W-1:0] idx;
    logic [7:0]       xor_acc;
    logic             too_long;

    assign advance  = !out_valid_reg || res.ready;
    assign rx.ready = !in_valid_reg || advance;

    assign idx      = pos_reg - POS_BODY;
    assign xor_acc  = xor_reg ^ in_byte_reg;
    assign too_long = {1'b0, length_reg} > POS_W'(MAX_BODY);

    always_comb
    begin
        pos_next    = pos_reg;
        xor_next    = xor_reg;
        length_next = length_reg;
        seq_next    = seq_reg;
        emit        = 1'b0;
        data_next   = 8'd0;
        offset_next = 10'd0;
        last_next   = 1'b0;
        status_next = ST_OK;
        case (pos_reg)
            POS_START:
            begin
                if (in_byte_reg == cfg.start_value)
                begin
                    pos_next = POS_SEQ;
                    xor_next = in_byte_reg;
                end
            end
            POS_SEQ:
            begin
                seq_next = in_byte_reg;
                xor_next = xor_acc;
                pos_next = POS_LEN_HI;
            end
            POS_LEN_HI:
            begin
                length_next = {in_byte_reg, 8'd0};
                xor_next    = xor_acc;
                pos_next    = POS_LEN_LO;
            end
            POS_LEN_LO:
            begin
                length_next = {length_reg[15:8], in_byte_reg};
                xor_next    = xor_acc;
                pos_next    = POS_TOKEN;
            end
            POS_TOKEN:
            begin
                if (in_byte_reg == cfg.token_value)
                begin
                    xor_next = xor_acc;
                    pos_next = POS_BODY;
                end
                else
                begin
                    xor_next = 8'd0;
                    pos_next = POS_START;
                end
            end
            default:
            begin
                if (idx < {1'b0, length_reg})
                begin
                    xor_next    = xor_acc;
                    pos_next    = pos_reg + POS_W'(1);
                    emit        = !too_long;
                    data_next   = in_byte_reg;
                    offset_next = idx[OFFSET_W-1:0];
                end
                else
                begin
                    emit      = 1'b1;
                    last_next = 1'b1;
                    if (too_long)
                    begin
                        status_next = ST_TOO_LONG;
                    end
                    else if (xor_acc != 8'd0)
                    begin
                        status_next = ST_CKSUM;
                    end
                    xor_next = 8'd0;
                    pos_next = POS_START;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_START;
            xor_reg       <= 8'd0;
            length_reg    <= 16'd0;
            seq_reg       <= 8'd0;
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg && emit;
            end
            if (in_valid_reg && advance)
            begin
                pos_reg    <= pos_next;
                xor_reg    <= xor_next;
                length_reg <= length_next;
                seq_reg    <= seq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (in_valid_reg && advance)
        begin
            out_data_reg   <= data_next;
            out_offset_reg <= offset_next;
            out_last_reg   <= last_next;
            out_status_reg <= status_next;
            out_seq_reg    <= seq_reg;
            out_length_reg <= length_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.data_byte    = out_data_reg;
    assign res.offset       = out_offset_reg;
    assign res.last         = out_last_reg;
    assign res.status       = out_status_reg;
    assign res.sequence_res = out_seq_reg;
    assign res.body_length  = out_length_reg;

    // The checksum accumulator is clear whenever a new message is awaited.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg == POS_START |-> xor_reg == 8'd0)
        else $error("running checksum not cleared while awaiting start");

    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_MAX)
        else $error("message position out of range");

    // A body word is never produced for a message that exceeds the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_last_reg |-> {1'b0, out_length_reg} <= POS_W'(MAX_BODY))
        else $error("body word emitted for an oversized message");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_last_reg |-> out_status_reg == ST_OK)
        else $error("nonzero status on a body word");

    // Result words, body and status alike, are produced only after a complete header.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance && emit |-> pos_reg >= POS_BODY)
        else $error("result produced inside the header");

endmodule

>>> src/stk500v2_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// stk500v2_frame_receiver_top: STK500v2 message receiver
// The receiver takes one serial byte per cycle on the rx channel and
// sustains that rate for as long as the result channel keeps up. Each byte
// is captured in an input register and handled, once the result channel can
// take a word, by a single compare, XOR and position update, whose result
// word is registered in the output register. Body bytes come out with their
// offset, and the checksum byte produces a final word with last set and the
// message status; bodies longer than MAX_BODY produce only the final word.
// The expected start and token bytes are APB registers at addresses 0 and 4.
// ----------------------------------------------------------------------------
module stk500v2_frame_receiver_top
    import stk_pkg::*;
#(
    parameter int unsigned MAX_BODY = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    stk_rx_if.sink             rx,
    stk_res_if.source          res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t cfg;

    stk_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stk_frame_core #(
        .MAX_BODY (MAX_BODY)
    ) u_frame_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .rx    (rx),
        .res   (res)
    );

endmodule
